FILE: rtl/itl_pkg.sv
// Shared widths, codes and types of the irregular-table interpolator.
package itl_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int PROD_W = 2 * DATA_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] POINT_COUNT_RESET = CNT_W'(1);

  typedef struct packed {
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] ap;
    logic signed [DATA_W-1:0] co;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/itl_in_if.sv
// Input channel of the interpolator: table loads and queries.
interface itl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic [itl_pkg::IDX_W-1:0]             entry_index;
  logic signed [itl_pkg::DATA_W-1:0]     entry_time;
  logic signed [itl_pkg::DATA_W-1:0]     entry_aperture;
  logic signed [itl_pkg::DATA_W-1:0]     entry_cutoff;
  logic signed [itl_pkg::DATA_W-1:0]     query_time;

  modport source(output valid, opcode, entry_index, entry_time, entry_aperture,
                 entry_cutoff, query_time, input ready);
  modport sink(input valid, opcode, entry_index, entry_time, entry_aperture,
               entry_cutoff, query_time, output ready);
endinterface

FILE: rtl/itl_out_if.sv
// Output channel of the interpolator: interpolated results.
interface itl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [itl_pkg::DATA_W-1:0] aperture_out;
  logic signed [itl_pkg::DATA_W-1:0] cutoff_out;

  modport source(output valid, aperture_out, cutoff_out, input ready);
  modport sink(input valid, aperture_out, cutoff_out, output ready);
endinterface

FILE: rtl/itl_div.sv
// Shift-subtract divider, one quotient bit per cycle, for quotients that fit 32 bits.
module itl_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [itl_pkg::PROD_W-1:0]      dividend,
  input  logic [itl_pkg::DATA_W-1:0]      divisor,
  output logic [itl_pkg::DATA_W-1:0]      quotient,
  output itl_pkg::div_status_t            status
);

  localparam int STEP_W = $clog2(itl_pkg::DATA_W);

  logic [itl_pkg::DATA_W-1:0] rem;
  logic [itl_pkg::DATA_W-1:0] dq;
  logic [itl_pkg::DATA_W-1:0] dvs;
  logic [STEP_W-1:0]          step;
  logic                       busy;
  logic                       done;
  logic [itl_pkg::DATA_W:0]   trial;
  logic                       fits;

  assign trial = {rem, dq[itl_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(itl_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[itl_pkg::PROD_W-1:itl_pkg::DATA_W];
      dq  <= dividend[itl_pkg::DATA_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? itl_pkg::DATA_W'(trial - {1'b0, dvs})
                  : trial[itl_pkg::DATA_W-1:0];
      dq  <= {dq[itl_pkg::DATA_W-2:0], fits};
    end
  end

  assign quotient    = dq;
  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: rtl/irregular_table_linear_interp.sv
// Top level of the irregular-table piecewise linear interpolator.
// A load item writes one breakpoint. A query item reads entry 0 and the
// last entry, then scans the table one entry per cycle through the single
// read port of the breakpoint memory, and finally runs the shift-subtract
// divider once for aperture and once for cutoff. A channel whose query sits
// exactly on the left breakpoint skips the divider, and a query that clamps
// to an end value skips the scan. A result waits in the output register
// while the next item is accepted.
module irregular_table_linear_interp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [itl_pkg::CNT_W-1:0]  cfg_wdata,
  itl_in_if.sink                     req,
  itl_out_if.source                  rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int DW = itl_pkg::DATA_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_LAST  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_START = 7'b0100000,
    S_DIV   = 7'b1000000
  } state_t;

  state_t state;

  logic [itl_pkg::CNT_W-1:0] point_count;
  logic [AW-1:0]             last_idx;

  itl_pkg::entry_t mem [MAX_POINTS];
  itl_pkg::entry_t rd_data;
  logic [AW-1:0]   rd_addr;
  logic [AW+itl_pkg::IDX_W-1:0] wr_idx_ext;
  logic            wr_en;

  logic signed [DW-1:0] q;
  itl_pkg::entry_t      left;
  itl_pkg::entry_t      right;
  logic [AW-1:0]        scan_idx;
  logic                 ch_cut;
  logic                 pending;

  logic signed [DW-1:0] y1;
  logic signed [DW-1:0] y2;
  logic signed [DW:0]   den;
  logic signed [DW:0]   dx;
  logic signed [DW:0]   dy;
  logic [DW:0]          mag;
  logic [itl_pkg::PROD_W-1:0] prod;

  logic [itl_pkg::PROD_W-1:0] prod_r;
  logic [DW-1:0]              den_r;
  logic signed [DW-1:0]       y1_r;
  logic                       neg_r;
  logic signed [DW-1:0]       res_ap;
  logic signed [DW-1:0]       res_co;
  logic signed [DW-1:0]       blended;

  logic [DW-1:0]         quotient;
  itl_pkg::div_status_t  div_stat;
  logic                  div_start;

  logic                  out_valid;
  logic                  out_load;
  logic signed [DW-1:0]  out_ap;
  logic signed [DW-1:0]  out_co;

  always_comb begin
    if (point_count == '0) begin
      last_idx = '0;
    end else if (32'(point_count) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(point_count - itl_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= itl_pkg::POINT_COUNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  assign req.ready  = (state == S_IDLE) && !pending;
  assign wr_idx_ext = {{AW{1'b0}}, req.entry_index};
  assign wr_en      = req.valid && req.ready && (req.opcode == itl_pkg::OP_LOAD)
                      && (32'(req.entry_index) < MAX_POINTS);

  always_comb begin
    unique case (state)
      S_FIRST: rd_addr = last_idx;
      S_LAST:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = scan_idx + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_ext[AW-1:0]] <= '{t: req.entry_time, ap: req.entry_aperture,
                                    co: req.entry_cutoff};
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    y1   = ch_cut ? left.co : left.ap;
    y2   = ch_cut ? right.co : right.ap;
    den  = $signed({right.t[DW-1], right.t}) - $signed({left.t[DW-1], left.t});
    dx   = $signed({q[DW-1], q}) - $signed({left.t[DW-1], left.t});
    dy   = $signed({y2[DW-1], y2}) - $signed({y1[DW-1], y1});
    mag  = dy[DW] ? (DW+1)'(-dy) : dy;
    prod = itl_pkg::PROD_W'(dx[DW-1:0]) * itl_pkg::PROD_W'(mag[DW-1:0]);
  end

  assign blended   = neg_r ? y1_r - $signed(quotient) : y1_r + $signed(quotient);
  assign div_start = (state == S_START);
  assign out_load  = pending && (!out_valid || rsp.ready);

  itl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .quotient (quotient),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      ch_cut    <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready && (req.opcode == itl_pkg::OP_QUERY)) begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          state <= S_LAST;
        end
        S_LAST: begin
          if ($signed(q) < $signed(left.t) || $signed(q) >= $signed(rd_data.t)) begin
            pending <= 1'b1;
            state   <= S_IDLE;
          end else begin
            scan_idx <= AW'(1);
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ($signed(rd_data.t) > $signed(q) || scan_idx == last_idx) begin
            ch_cut <= 1'b0;
            state  <= S_MUL;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        S_MUL: begin
          if (den <= 0 || dx <= 0) begin
            if (ch_cut) begin
              pending <= 1'b1;
              state   <= S_IDLE;
            end else begin
              ch_cut <= 1'b1;
            end
          end else begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (ch_cut) begin
              pending <= 1'b1;
              state   <= S_IDLE;
            end else begin
              ch_cut <= 1'b1;
              state  <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        q <= req.query_time;
      end
      S_FIRST: begin
        left <= rd_data;
      end
      S_LAST: begin
        if ($signed(q) < $signed(left.t)) begin
          res_ap <= left.ap;
          res_co <= left.co;
        end else begin
          res_ap <= rd_data.ap;
          res_co <= rd_data.co;
        end
      end
      S_SCAN: begin
        if ($signed(rd_data.t) > $signed(q) || scan_idx == last_idx) begin
          right <= rd_data;
        end else begin
          left <= rd_data;
        end
      end
      S_MUL: begin
        prod_r <= prod;
        den_r  <= den[DW-1:0];
        y1_r   <= y1;
        neg_r  <= dy[DW];
        if (den <= 0 || dx <= 0) begin
          if (ch_cut) begin
            res_co <= y1;
          end else begin
            res_ap <= y1;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (ch_cut) begin
            res_co <= blended;
          end else begin
            res_ap <= blended;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_ap <= res_ap;
      out_co <= res_co;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.aperture_out = out_ap;
  assign rsp.cutoff_out   = out_co;

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |-> !div_stat.busy)
    else $error("Divider started while still busy.");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("Divider finished outside the wait state.");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= last_idx && scan_idx != '0))
    else $error("Scan index left the active table.");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (rsp.valid && !pending))
    else $error("Finished result did not reach the output register.");

endmodule

FILE: tb/irregular_table_linear_interp_test.sv
// Self-checking testbench of the irregular-table piecewise linear interpolator.
`timescale 1ns / 1ps
module irregular_table_linear_interp_test;

  localparam int MAX_PTS = 64;
  localparam int RAND_PHASES = 24;
  localparam int QUERIES_PER_PHASE = 22;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 150;
  localparam logic [itl_pkg::CNT_W-1:0] CNT_MAX = '1;
  localparam logic signed [itl_pkg::DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [itl_pkg::DATA_W-1:0] NEG_MAX = 32'sh8000_0000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic signed [itl_pkg::DATA_W-1:0] ap;
    logic signed [itl_pkg::DATA_W-1:0] co;
  } interp_pair_t;

  typedef struct packed {
    logic                              op;
    logic [itl_pkg::IDX_W-1:0]         idx;
    logic signed [itl_pkg::DATA_W-1:0] t;
    logic signed [itl_pkg::DATA_W-1:0] ap;
    logic signed [itl_pkg::DATA_W-1:0] co;
    logic signed [itl_pkg::DATA_W-1:0] q;
  } table_item_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [itl_pkg::CNT_W-1:0] cfg;
    table_item_t               item;
    logic                      has_want;
    interp_pair_t              want;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [itl_pkg::CNT_W-1:0] cfg_wdata;

  itl_in_if  req_if ();
  itl_out_if rsp_if ();

  irregular_table_linear_interp #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic signed [itl_pkg::DATA_W-1:0] bp_time [MAX_PTS];
  logic signed [itl_pkg::DATA_W-1:0] ap_tab [MAX_PTS];
  logic signed [itl_pkg::DATA_W-1:0] co_tab [MAX_PTS];
  logic [itl_pkg::CNT_W-1:0]         npoints_reg;

  interp_pair_t expected_pairs [$];
  stim_row_t    directed_rows [$];
  interp_pair_t oldest_pair;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [itl_pkg::DATA_W-1:0] blend_value(longint q, longint t1,
                                                                   longint t2, longint y1,
                                                                   longint y2);
    longint den;
    longint dx;
    longint dy;
    longint unsigned mag;
    longint unsigned quot;
    den = t2 - t1;
    dx = q - t1;
    dy = y2 - y1;
    if (den <= 0 || dx <= 0) begin
      return itl_pkg::DATA_W'(y1);
    end
    mag = (dy < 0) ? longint'(-dy) : longint'(dy);
    quot = (longint'(dx) * mag) / longint'(den);
    if (dy < 0) begin
      return itl_pkg::DATA_W'(y1 - longint'(quot));
    end
    return itl_pkg::DATA_W'(y1 + longint'(quot));
  endfunction

  function automatic interp_pair_t interp_at(logic signed [itl_pkg::DATA_W-1:0] q);
    int n;
    int last;
    int hi;
    interp_pair_t r;
    n = (npoints_reg < 1) ? 1 : (npoints_reg > MAX_PTS) ? MAX_PTS : int'(npoints_reg);
    last = n - 1;
    if (q < bp_time[0]) begin
      r.ap = ap_tab[0];
      r.co = co_tab[0];
    end else if (q >= bp_time[last]) begin
      r.ap = ap_tab[last];
      r.co = co_tab[last];
    end else begin
      hi = 1;
      while (hi < last && bp_time[hi] <= q) hi++;
      r.ap = blend_value(q, bp_time[hi-1], bp_time[hi], ap_tab[hi-1], ap_tab[hi]);
      r.co = blend_value(q, bp_time[hi-1], bp_time[hi], co_tab[hi-1], co_tab[hi]);
    end
    return r;
  endfunction

  function automatic table_item_t load_item(logic [itl_pkg::IDX_W-1:0] idx,
                                            logic signed [itl_pkg::DATA_W-1:0] t,
                                            logic signed [itl_pkg::DATA_W-1:0] ap,
                                            logic signed [itl_pkg::DATA_W-1:0] co);
    table_item_t it;
    it.op = itl_pkg::OP_LOAD;
    it.idx = idx;
    it.t = t;
    it.ap = ap;
    it.co = co;
    it.q = $urandom;
    return it;
  endfunction

  function automatic table_item_t query_item(logic signed [itl_pkg::DATA_W-1:0] q);
    table_item_t it;
    it.op = itl_pkg::OP_QUERY;
    it.idx = itl_pkg::IDX_W'($urandom);
    it.t = $urandom;
    it.ap = $urandom;
    it.co = $urandom;
    it.q = q;
    return it;
  endfunction

  function automatic logic signed [itl_pkg::DATA_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return POS_MAX;
      1: return NEG_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [itl_pkg::DATA_W-1:0] pick_query(int n);
    int i;
    longint lo;
    longint span;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return bp_time[i];
      1: return bp_time[0] - 1;
      2: return $urandom;
      3: return bp_time[n-1] + $urandom_range(0, 255);
      default: begin
        if (n < 2) begin
          return $urandom;
        end
        i = $urandom_range(0, n - 2);
        lo = bp_time[i];
        span = longint'(bp_time[i+1]) - lo;
        if (span <= 0) begin
          return $urandom;
        end
        return itl_pkg::DATA_W'(lo + longint'({$urandom, $urandom} % longint'(span)));
      end
    endcase
  endfunction

  function automatic void set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 51;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 51;
      end
      default: begin
        send_idle_pct = 35;
        stall_pct = 35;
      end
    endcase
  endfunction

  function automatic void add_item(table_item_t it);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic signed [itl_pkg::DATA_W-1:0] q,
                                      logic signed [itl_pkg::DATA_W-1:0] ap,
                                      logic signed [itl_pkg::DATA_W-1:0] co);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = query_item(q);
    r.has_want = 1'b1;
    r.want.ap = ap;
    r.want.co = co;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [itl_pkg::CNT_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg = v;
    directed_rows.push_back(r);
  endfunction

  task automatic send_item(input table_item_t it, input logic has_want, input interp_pair_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= it.op;
    req_if.entry_index <= it.idx;
    req_if.entry_time <= it.t;
    req_if.entry_aperture <= it.ap;
    req_if.entry_cutoff <= it.co;
    req_if.query_time <= it.q;
    do @(posedge clk); while (!req_if.ready);
    if (it.op == itl_pkg::OP_LOAD) begin
      bp_time[it.idx] = it.t;
      ap_tab[it.idx] = it.ap;
      co_tab[it.idx] = it.co;
      n_loads++;
    end else begin
      expected_pairs.push_back(has_want ? want : interp_at(it.q));
      n_queries++;
    end
  endtask

  task automatic drain_block();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_point_count(input logic [itl_pkg::CNT_W-1:0] v);
    drain_block();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    npoints_reg = v;
    n_settings++;
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got aperture %h cutoff %h", $time,
                 rsp_if.aperture_out, rsp_if.cutoff_out);
        n_errors++;
      end else begin
        oldest_pair = expected_pairs.pop_front();
        n_results++;
        if (rsp_if.aperture_out !== oldest_pair.ap) begin
          $display("%0t: aperture_out mismatch, expected %h, got %h", $time, oldest_pair.ap,
                   rsp_if.aperture_out);
          n_errors++;
        end
        if (rsp_if.cutoff_out !== oldest_pair.co) begin
          $display("%0t: cutoff_out mismatch, expected %h, got %h", $time, oldest_pair.co,
                   rsp_if.cutoff_out);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_pairs.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n;
    int kind;
    int base;
    logic [itl_pkg::CNT_W-1:0] cfg_val;
    int tq [$];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.opcode = itl_pkg::OP_LOAD;
    req_if.entry_index = '0;
    req_if.entry_time = '0;
    req_if.entry_aperture = '0;
    req_if.entry_cutoff = '0;
    req_if.query_time = '0;
    npoints_reg = itl_pkg::POINT_COUNT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_item(load_item(0, 32'sh0, POS_MAX, NEG_MAX));
    add_checked(NEG_MAX, POS_MAX, NEG_MAX);
    add_checked(POS_MAX, POS_MAX, NEG_MAX);
    add_checked(32'sh0, POS_MAX, NEG_MAX);
    add_cfg(0);
    add_checked(32'sh1, POS_MAX, NEG_MAX);
    add_item(load_item(1, 32'sh0001_0000, NEG_MAX, POS_MAX));
    add_item(load_item(2, 32'sh0001_0000, 32'sh0, 32'sh0));
    add_item(load_item(3, POS_MAX, 32'shFFFF_FFFF, 32'sh1));
    add_cfg(2);
    add_item(query_item(32'sh0000_8000));
    add_checked(32'sh0001_0000, NEG_MAX, POS_MAX);
    add_checked(32'shFFFF_FFFF, POS_MAX, NEG_MAX);
    add_checked(32'sh0, POS_MAX, NEG_MAX);
    add_cfg(4);
    add_checked(32'sh0001_0000, 32'sh0, 32'sh0);
    add_item(query_item(32'sh4000_0000));
    add_item(query_item(32'sh7FFF_FFFE));
    add_checked(POS_MAX, 32'shFFFF_FFFF, 32'sh1);
    add_item(load_item(0, NEG_MAX, 32'sh1, 32'shFFFF_FFFF));
    add_checked(NEG_MAX, 32'sh1, 32'shFFFF_FFFF);
    add_item(query_item(32'sh8000_0001));
    add_item(query_item(32'shC000_0000));
    add_cfg(3);
    add_checked(32'sh0001_0000, 32'sh0, 32'sh0);

    set_idling(IDLE_BOTH);
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_point_count(directed_rows[r].cfg);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].has_want, directed_rows[r].want);
      end
    end

    // Every entry is written once here, so later settings never read an unwritten one.
    set_idling(IDLE_NONE);
    base = $signed($urandom) >>> 5;
    for (int i = 0; i < MAX_PTS; i++) begin
      send_item(load_item(itl_pkg::IDX_W'(i), base, rand_level(), rand_level()), 1'b0, '0);
      base += $urandom_range(1, 1 << 18);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(idle_mode_t'(ph % 4));
      kind = $urandom_range(0, 19);
      n = (kind == 0) ? 1 : (kind < 14) ? $urandom_range(2, 8) :
          (kind < 17) ? $urandom_range(9, 63) : MAX_PTS;
      if (ph == 1 || ph == 2) n = MAX_PTS;
      cfg_val = itl_pkg::CNT_W'(n);
      if (n == MAX_PTS) begin
        if (ph == 1) cfg_val = CNT_MAX;
        else if (ph != 2 && $urandom_range(0, 1))
          cfg_val = itl_pkg::CNT_W'($urandom_range(MAX_PTS + 1, CNT_MAX));
      end else if (n == 1 && $urandom_range(0, 1)) begin
        cfg_val = 0;
      end

      tq.delete();
      kind = $urandom_range(0, 9);
      if (kind >= 4 && kind < 8) begin
        base = $signed($urandom) >>> 5;
        for (int i = 0; i < n; i++) begin
          tq.push_back(base);
          base += $urandom_range(1, 1 << 18);
        end
      end else begin
        for (int i = 0; i < n; i++) tq.push_back($urandom);
        if (kind < 4) tq.sort();
        else if (n > 1) tq[n-1] = tq[n-2];
      end
      for (int i = 0; i < n; i++) begin
        send_item(load_item(itl_pkg::IDX_W'(i), tq[i], rand_level(), rand_level()), 1'b0,
                  '0);
      end

      write_point_count(cfg_val);
      for (int k = 0; k < QUERIES_PER_PHASE; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(load_item(itl_pkg::IDX_W'($urandom), $urandom, rand_level(),
                              rand_level()), 1'b0, '0);
        end else begin
          send_item(query_item(pick_query(n)), 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d loads and %0d queries over %0d point-count settings.", n_loads,
             n_queries, n_settings);
    $display("Checked %0d results, %0d errors.", n_results, n_errors);
    if (n_errors == 0 && expected_pairs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/itl_pkg.sv
rtl/itl_in_if.sv
rtl/itl_out_if.sv
rtl/itl_div.sv
rtl/irregular_table_linear_interp.sv
tb/irregular_table_linear_interp_test.sv
